// ===== src/bsbe_pkg.sv =====
// Package for the byte-stack bytecode executor: sizes, opcodes, type codes
// and the structs passed between the sequencer, the stack memory and the FPU.
// No dependencies.
package bsbe_pkg;

   // Stack and program counter sizes.
   localparam int STACK_DEPTH_BYTES = 4096;
   localparam int PC_WIDTH          = 16;
   localparam int ADDR_W            = $clog2(STACK_DEPTH_BYTES);
   localparam int PTR_W             = $clog2(STACK_DEPTH_BYTES + 1);

   // Signed width for address arithmetic with a 32-bit signed offset.
   localparam int XW = ((PTR_W > 32) ? PTR_W : 32) + 4;

   // Byte buffer for one instruction: up to sixteen bytes.
   localparam int BUF_BYTES  = 16;
   localparam int CNT_W      = 4;
   localparam int LEN_W      = 5;
   localparam int INIT_BYTES = 16;

   // Stream widths.
   localparam int REQ_FIELDS_W = 4 + 32 + 32;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = PC_WIDTH + 1 + 1 + 1 + 32 + 1 + 1;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Value type codes used by the convert instruction.
   localparam logic [31:0] TYPE_FLOAT = 32'd2;
   localparam logic [31:0] TYPE_BOOL  = 32'd3;
   localparam logic [31:0] TYPE_INT   = 32'd4;

   // Float constants.
   localparam logic [31:0] FLOAT_ONE    = 32'h3F80_0000;
   localparam logic [31:0] FLOAT_QNAN   = 32'hFFC0_0000;
   localparam logic [31:0] INT_MAX_BITS = 32'h7FFF_FFFF;
   localparam logic [31:0] INT_MIN_BITS = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_EXIT      = 4'd0,
      OP_PUSH      = 4'd1,
      OP_POP       = 4'd2,
      OP_LOAD      = 4'd3,
      OP_LOADPARAM = 4'd4,
      OP_STORE     = 4'd5,
      OP_JUMP      = 4'd6,
      OP_JIFNOT    = 4'd7,
      OP_JIFEQ     = 4'd8,
      OP_CALL      = 4'd9,
      OP_RET       = 4'd10,
      OP_CONVERT   = 4'd11,
      OP_ADD       = 4'd12,
      OP_PRINT     = 4'd13,
      OP_TEST      = 4'd14,
      OP_LESS      = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      FOP_ADD,
      FOP_EQ,
      FOP_LT,
      FOP_F2I
   } fpu_op_type;

   typedef struct packed {
      logic        start;
      fpu_op_type  op;
      logic [31:0] x;
      logic [31:0] y;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
      logic        flag;
   } fpu_rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

endpackage

// ===== src/bsbe_stack_ram.sv =====
// Byte-wide single-port stack memory with a registered read.
// Depends on bsbe_pkg for the depth and the port struct.
module bsbe_stack_ram import bsbe_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata
);

   logic [7:0] mem [STACK_DEPTH_BYTES];
   logic [7:0] rdata_ff;

   // One access per cycle: write when enabled, always read the addressed byte.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bsbe_fpu.sv =====
// Shared single-precision unit: add with iterative normalization, compare
// equal, compare less-than and float-to-int conversion.
// Depends on bsbe_pkg for the request and response structs.
module bsbe_fpu import bsbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fpu_req_type fpu_req,
   output fpu_rsp_type fpu_rsp
);

   typedef enum logic [1:0] {F_IDLE, F_ALIGN, F_NORM, F_ROUND} fstate_type;

   fstate_type  state_ff, state_in;
   logic        done_ff, done_in;
   logic [31:0] result_ff, result_in;
   logic        flag_ff, flag_in;
   logic        sign_ff, sign_in;
   logic        zsign_ff, zsign_in;
   logic        sub_ff, sub_in;
   logic [9:0]  exp_ff, exp_in;
   logic [23:0] big_ff, big_in;
   logic [23:0] small_ff, small_in;
   logic [7:0]  diff_ff, diff_in;
   logic [27:0] sum_ff, sum_in;

   // Operand classification.
   logic [31:0] x, y;
   logic        x_nan, y_nan, x_inf, y_inf, x_ge;
   logic [31:0] big_w, small_w;
   logic [7:0]  eb, es;
   logic        eq_res, lt_res;
   logic [31:0] f2i_res;
   logic [31:0] f2i_mag;
   logic [26:0] small27, shifted, mask27;
   logic        sticky;
   logic [30:0] packed_w;
   logic        round_up;

   always_comb begin
      x       = fpu_req.x;
      y       = fpu_req.y;
      x_nan   = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      y_nan   = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
      x_inf   = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      y_inf   = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
      x_ge    = x[30:0] >= y[30:0];
      big_w   = x_ge ? x : y;
      small_w = x_ge ? y : x;
      eb      = (big_w[30:23] == 8'd0) ? 8'd1 : big_w[30:23];
      es      = (small_w[30:23] == 8'd0) ? 8'd1 : small_w[30:23];

      // Equality: NaN never equal, signed zeros equal.
      if (x_nan || y_nan) begin
         eq_res = 1'b0;
      end else if ((x[30:0] | y[30:0]) == 31'd0) begin
         eq_res = 1'b1;
      end else begin
         eq_res = (x == y);
      end

      // Less-than on sign-magnitude encodings.
      if (x_nan || y_nan || ((x[30:0] | y[30:0]) == 31'd0)) begin
         lt_res = 1'b0;
      end else if (x[31] != y[31]) begin
         lt_res = x[31];
      end else if (!x[31]) begin
         lt_res = x[30:0] < y[30:0];
      end else begin
         lt_res = x[30:0] > y[30:0];
      end

      // Float to int: truncate, saturate, NaN to zero.
      f2i_mag = 32'd0;
      if (x[30:23] >= 8'd150) begin
         f2i_mag = {8'd0, 1'b1, x[22:0]} << (x[30:23] - 8'd150);
      end else begin
         f2i_mag = {8'd0, 1'b1, x[22:0]} >> (8'd150 - x[30:23]);
      end
      if (x_nan) begin
         f2i_res = 32'd0;
      end else if (x[30:23] >= 8'd158) begin
         f2i_res = x[31] ? INT_MIN_BITS : INT_MAX_BITS;
      end else if (x[30:23] < 8'd127) begin
         f2i_res = 32'd0;
      end else begin
         f2i_res = x[31] ? (32'd0 - f2i_mag) : f2i_mag;
      end

      // Alignment of the smaller operand with a sticky bit.
      small27 = {small_ff, 3'b000};
      mask27  = (27'd1 << diff_ff[4:0]) - 27'd1;
      if (diff_ff >= 8'd27) begin
         shifted = 27'd0;
         sticky  = |small_ff;
      end else begin
         shifted = small27 >> diff_ff[4:0];
         sticky  = |(small27 & mask27);
      end

      // Round to nearest even on the packed exponent and fraction.
      packed_w = {(sum_ff[26] ? exp_ff[7:0] : 8'd0), sum_ff[25:3]};
      round_up = sum_ff[2] && (sum_ff[1] || sum_ff[0] || sum_ff[3]);
   end

   // Next-state logic.
   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      flag_in   = flag_ff;
      sign_in   = sign_ff;
      zsign_in  = zsign_ff;
      sub_in    = sub_ff;
      exp_in    = exp_ff;
      big_in    = big_ff;
      small_in  = small_ff;
      diff_in   = diff_ff;
      sum_in    = sum_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (fpu_req.start) begin
               unique case (fpu_req.op)
                  FOP_EQ: begin
                     flag_in = eq_res;
                     done_in = 1'b1;
                  end
                  FOP_LT: begin
                     flag_in = lt_res;
                     done_in = 1'b1;
                  end
                  FOP_F2I: begin
                     result_in = f2i_res;
                     done_in   = 1'b1;
                  end
                  FOP_ADD: begin
                     if (x_nan) begin
                        result_in = x | 32'h0040_0000;
                        done_in   = 1'b1;
                     end else if (y_nan) begin
                        result_in = y | 32'h0040_0000;
                        done_in   = 1'b1;
                     end else if (x_inf && y_inf && (x[31] != y[31])) begin
                        result_in = FLOAT_QNAN;
                        done_in   = 1'b1;
                     end else if (x_inf) begin
                        result_in = x;
                        done_in   = 1'b1;
                     end else if (y_inf) begin
                        result_in = y;
                        done_in   = 1'b1;
                     end else begin
                        sign_in  = big_w[31];
                        zsign_in = x[31] & y[31];
                        sub_in   = x[31] ^ y[31];
                        exp_in   = {2'b00, eb};
                        big_in   = {(big_w[30:23] != 8'd0), big_w[22:0]};
                        small_in = {(small_w[30:23] != 8'd0), small_w[22:0]};
                        diff_in  = eb - es;
                        state_in = F_ALIGN;
                     end
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         F_ALIGN: begin
            if (sub_ff) begin
               sum_in = {1'b0, big_ff, 3'b000} - {1'b0, shifted | {26'd0, sticky}};
            end else begin
               sum_in = {1'b0, big_ff, 3'b000} + {1'b0, shifted | {26'd0, sticky}};
            end
            state_in = F_NORM;
         end
         F_NORM: begin
            // One normalization step per cycle.
            if (sum_ff == 28'd0) begin
               result_in = {zsign_ff, 31'd0};
               done_in   = 1'b1;
               state_in  = F_IDLE;
            end else if (sum_ff[27]) begin
               sum_in   = {1'b0, sum_ff[27:2], sum_ff[1] | sum_ff[0]};
               exp_in   = exp_ff + 10'd1;
               state_in = F_ROUND;
            end else if (!sum_ff[26] && (exp_ff > 10'd1)) begin
               sum_in = {sum_ff[26:0], 1'b0};
               exp_in = exp_ff - 10'd1;
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (exp_ff >= 10'd255) begin
               result_in = {sign_ff, 8'hFF, 23'd0};
            end else begin
               result_in = {sign_ff, packed_w + {30'd0, round_up}};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      result_ff <= result_in;
      flag_ff   <= flag_in;
      sign_ff   <= sign_in;
      zsign_ff  <= zsign_in;
      sub_ff    <= sub_in;
      exp_ff    <= exp_in;
      big_ff    <= big_in;
      small_ff  <= small_in;
      diff_ff   <= diff_in;
      sum_ff    <= sum_in;
   end

   assign fpu_rsp.done   = done_ff;
   assign fpu_rsp.result = result_ff;
   assign fpu_rsp.flag   = flag_ff;

endmodule

// ===== src/byte_stack_bytecode_executor.sv =====
// Top level of the byte-stack bytecode executor: sequencer, stack memory and FPU.
// Depends on bsbe_pkg, bsbe_stack_ram and bsbe_fpu.
//
// Executes one bytecode instruction per request on a little-endian byte stack
// held in a single-port byte memory, and returns the next program counter,
// halt and fault flags, and any print or test result. After reset the block
// zeroes the initial null return and base before it accepts a request. Stack
// bytes are read and written one at a time through the one byte-wide memory
// port, and the FPU serves compares, conversion and the float add with its
// bit-serial normalization. The block takes one request at a time and is not
// ready until its result has been registered for the output.
module byte_stack_bytecode_executor import bsbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: opcode[4], imm_first[32], imm_second[32], zero pad.
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // Fields from bit 0: next_pc[PC_WIDTH], halted, fault, print_valid,
   // print_value[32], test_valid, test_pass, zero pad.
   output logic [RSP_W-1:0] rsp_tdata
);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DECODE, ST_RD_ADDR, ST_RD_DATA,
      ST_EXEC, ST_FPU, ST_POST, ST_WR, ST_FIN
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   opcode_type               op_ff, op_in;
   logic [31:0]              a_ff, a_in;
   logic [31:0]              b_ff, b_in;
   logic [PTR_W-1:0]         sp_ff, sp_in;
   logic [PTR_W-1:0]         base_ff, base_in;
   logic [PC_WIDTH-1:0]      pc_ff, pc_in;
   logic                     stopped_ff, stopped_in;
   logic [ADDR_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0]         rd_len_ff, rd_len_in;
   logic [ADDR_W-1:0]        wr_addr_ff, wr_addr_in;
   logic [LEN_W-1:0]         wr_len_ff, wr_len_in;
   logic [PTR_W-1:0]         sp_new_ff, sp_new_in;
   logic                     fault_ff, fault_in;
   logic [BUF_BYTES*8-1:0]   word_ff, word_in;

   // Pending result and output register.
   logic [PC_WIDTH-1:0] res_pc_ff, res_pc_in;
   logic                res_halted_ff, res_halted_in;
   logic                res_fault_ff, res_fault_in;
   logic                res_pv_ff, res_pv_in;
   logic [31:0]         res_pval_ff, res_pval_in;
   logic                res_tv_ff, res_tv_in;
   logic                res_tp_ff, res_tp_in;
   logic [RSP_FIELDS_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   mem_req_type mem_req;
   logic [7:0]  mem_rdata;
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   // Decode results.
   logic                 d_fault;
   logic [ADDR_W-1:0]    d_rd_addr, d_wr_addr;
   logic [LEN_W-1:0]     d_rd_len, d_wr_len;
   logic [PTR_W-1:0]     d_sp_new;
   logic signed [XW-1:0] top_x, base_x, sa_x, ua_x, addr_x, depth_x;

   // Post-execute helpers.
   logic [PC_WIDTH-1:0] pc_plus1, pc_jmp_a, pc_jmp_b;
   logic [63:0]         rv, bv;
   logic                ret_bad;
   logic                need_fpu;
   logic                bool_v;

   bsbe_stack_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   bsbe_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   // Bounds checks and access plan for the instruction.
   always_comb begin
      top_x   = XW'(sp_ff);
      base_x  = XW'(base_ff);
      sa_x    = XW'(signed'(a_ff));
      ua_x    = XW'(a_ff);
      depth_x = XW'(STACK_DEPTH_BYTES);
      if (op_ff == OP_LOADPARAM) begin
         addr_x = base_x - XW'(16) - sa_x;
      end else begin
         addr_x = base_x + sa_x;
      end

      d_fault   = 1'b0;
      d_rd_addr = ADDR_W'(sp_ff - PTR_W'(4));
      d_rd_len  = '0;
      d_wr_addr = ADDR_W'(sp_ff);
      d_wr_len  = '0;
      d_sp_new  = sp_ff;

      unique case (op_ff)
         OP_PUSH: begin
            d_fault  = (top_x + 4) > depth_x;
            d_wr_len = LEN_W'(4);
            d_sp_new = sp_ff + PTR_W'(4);
         end
         OP_POP: begin
            d_fault  = ua_x > top_x;
            d_sp_new = sp_ff - a_ff[PTR_W-1:0];
         end
         OP_LOAD, OP_LOADPARAM: begin
            d_fault   = (addr_x < 0) || ((addr_x + 4) > top_x) || ((top_x + 4) > depth_x);
            d_rd_addr = addr_x[ADDR_W-1:0];
            d_rd_len  = LEN_W'(4);
            d_wr_len  = LEN_W'(4);
            d_sp_new  = sp_ff + PTR_W'(4);
         end
         OP_STORE: begin
            d_fault   = (top_x < 4) || (addr_x < 0) || ((addr_x + 4) > (top_x - 4));
            d_rd_len  = LEN_W'(4);
            d_wr_addr = addr_x[ADDR_W-1:0];
            d_wr_len  = LEN_W'(4);
            d_sp_new  = sp_ff - PTR_W'(4);
         end
         OP_JIFNOT: begin
            d_fault   = top_x < 1;
            d_rd_addr = ADDR_W'(sp_ff - PTR_W'(1));
            d_rd_len  = LEN_W'(1);
            d_sp_new  = sp_ff - PTR_W'(1);
         end
         OP_JIFEQ, OP_PRINT: begin
            d_fault  = top_x < 4;
            d_rd_len = LEN_W'(4);
            d_sp_new = sp_ff - PTR_W'(4);
         end
         OP_CALL: begin
            d_fault  = (top_x + 16) > depth_x;
            d_wr_len = LEN_W'(16);
            d_sp_new = sp_ff + PTR_W'(16);
         end
         OP_RET: begin
            d_fault   = top_x < 16;
            d_rd_addr = ADDR_W'(sp_ff - PTR_W'(16));
            d_rd_len  = LEN_W'(16);
            d_sp_new  = sp_ff - PTR_W'(16);
         end
         OP_CONVERT: begin
            if (a_ff == b_ff) begin
               d_fault = 1'b0;
            end else if (a_ff == TYPE_FLOAT) begin
               d_fault   = top_x < 4;
               d_rd_len  = LEN_W'(4);
               d_wr_addr = ADDR_W'(sp_ff - PTR_W'(4));
               if (b_ff == TYPE_BOOL) begin
                  d_wr_len = LEN_W'(1);
                  d_sp_new = sp_ff - PTR_W'(3);
               end else if (b_ff == TYPE_INT) begin
                  d_wr_len = LEN_W'(4);
               end else begin
                  d_sp_new = sp_ff - PTR_W'(4);
               end
            end else if (a_ff == TYPE_BOOL) begin
               d_fault   = (top_x < 1) || ((b_ff == TYPE_FLOAT) && ((top_x + 3) > depth_x));
               d_rd_addr = ADDR_W'(sp_ff - PTR_W'(1));
               d_rd_len  = LEN_W'(1);
               d_wr_addr = ADDR_W'(sp_ff - PTR_W'(1));
               if ((b_ff == TYPE_FLOAT) || (b_ff == TYPE_INT)) begin
                  d_wr_len = LEN_W'(4);
                  d_sp_new = sp_ff + PTR_W'(3);
               end else begin
                  d_sp_new = sp_ff - PTR_W'(1);
               end
            end
         end
         OP_ADD: begin
            d_fault   = top_x < 8;
            d_rd_addr = ADDR_W'(sp_ff - PTR_W'(8));
            d_rd_len  = LEN_W'(8);
            d_wr_addr = ADDR_W'(sp_ff - PTR_W'(8));
            d_wr_len  = LEN_W'(4);
            d_sp_new  = sp_ff - PTR_W'(4);
         end
         OP_TEST: begin
            d_fault   = top_x < 8;
            d_rd_addr = ADDR_W'(sp_ff - PTR_W'(8));
            d_rd_len  = LEN_W'(8);
            d_sp_new  = sp_ff - PTR_W'(8);
         end
         OP_LESS: begin
            d_fault   = top_x < 8;
            d_rd_addr = ADDR_W'(sp_ff - PTR_W'(8));
            d_rd_len  = LEN_W'(8);
            d_wr_addr = ADDR_W'(sp_ff - PTR_W'(8));
            d_wr_len  = LEN_W'(1);
            d_sp_new  = sp_ff - PTR_W'(7);
         end
         default: begin
            d_fault = 1'b0;
         end
      endcase
   end

   // FPU request, issued from the execute state.
   always_comb begin
      need_fpu  = 1'b0;
      fpu_req.op = FOP_EQ;
      fpu_req.x  = word_ff[63:32];
      fpu_req.y  = word_ff[31:0];
      case (op_ff)
         OP_JIFEQ: begin
            need_fpu  = 1'b1;
            fpu_req.x = a_ff;
         end
         OP_ADD: begin
            need_fpu   = 1'b1;
            fpu_req.op = FOP_ADD;
         end
         OP_TEST: begin
            need_fpu = 1'b1;
         end
         OP_LESS: begin
            need_fpu   = 1'b1;
            fpu_req.op = FOP_LT;
            fpu_req.x  = word_ff[31:0];
            fpu_req.y  = word_ff[63:32];
         end
         OP_CONVERT: begin
            need_fpu   = (a_ff == TYPE_FLOAT) && (b_ff == TYPE_INT);
            fpu_req.op = FOP_F2I;
            fpu_req.x  = word_ff[31:0];
         end
         default: begin
            need_fpu = 1'b0;
         end
      endcase
      need_fpu      = need_fpu && !stopped_ff && !fault_ff;
      fpu_req.start = (state_ff == ST_EXEC) && need_fpu;
   end

   // Stack memory port.
   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.addr  = rd_addr_ff + ADDR_W'(cnt_ff);
      mem_req.wdata = word_ff[{cnt_ff, 3'b000} +: 8];
      if (state_ff == ST_INIT) begin
         mem_req.we    = 1'b1;
         mem_req.addr  = ADDR_W'(cnt_ff);
         mem_req.wdata = 8'd0;
      end else if (state_ff == ST_WR) begin
         mem_req.we   = 1'b1;
         mem_req.addr = wr_addr_ff + ADDR_W'(cnt_ff);
      end
   end

   // Sequencer.
   always_comb begin
      pc_plus1 = pc_ff + PC_WIDTH'(1);
      pc_jmp_a = pc_ff + a_ff[PC_WIDTH-1:0];
      pc_jmp_b = pc_ff + b_ff[PC_WIDTH-1:0];
      rv       = word_ff[63:0];
      bv       = word_ff[127:64];
      ret_bad  = (op_ff == OP_RET) && (bv > 64'(STACK_DEPTH_BYTES));
      bool_v   = word_ff[7:0] != 8'd0;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      sp_in         = sp_ff;
      base_in       = base_ff;
      pc_in         = pc_ff;
      stopped_in    = stopped_ff;
      rd_addr_in    = rd_addr_ff;
      rd_len_in     = rd_len_ff;
      wr_addr_in    = wr_addr_ff;
      wr_len_in     = wr_len_ff;
      sp_new_in     = sp_new_ff;
      fault_in      = fault_ff;
      word_in       = word_ff;
      res_pc_in     = res_pc_ff;
      res_halted_in = res_halted_ff;
      res_fault_in  = res_fault_ff;
      res_pv_in     = res_pv_ff;
      res_pval_in   = res_pval_ff;
      res_tv_in     = res_tv_ff;
      res_tp_in     = res_tp_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_INIT: begin
            // Zero the null return address and base after reset.
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(INIT_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = opcode_type'(req_tdata[3:0]);
               a_in     = req_tdata[35:4];
               b_in     = req_tdata[67:36];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            rd_addr_in = d_rd_addr;
            rd_len_in  = d_rd_len;
            wr_addr_in = d_wr_addr;
            wr_len_in  = d_wr_len;
            sp_new_in  = d_sp_new;
            fault_in   = d_fault;
            cnt_in     = '0;
            if (stopped_ff || d_fault || (d_rd_len == '0)) begin
               state_in = ST_EXEC;
            end else begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            // Gather the stack bytes little-endian into the buffer.
            word_in[{cnt_ff, 3'b000} +: 8] = mem_rdata;
            if ((LEN_W'(cnt_ff) + LEN_W'(1)) == rd_len_ff) begin
               cnt_in   = '0;
               state_in = ST_EXEC;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_RD_ADDR;
            end
         end
         ST_EXEC: begin
            state_in = need_fpu ? ST_FPU : ST_POST;
         end
         ST_FPU: begin
            if (fpu_rsp.done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            res_fault_in = 1'b0;
            res_pv_in    = 1'b0;
            res_pval_in  = 32'd0;
            res_tv_in    = 1'b0;
            res_tp_in    = 1'b0;
            res_pc_in    = pc_ff;
            cnt_in       = '0;
            state_in     = ST_FIN;
            if (stopped_ff) begin
               res_halted_in = 1'b1;
            end else if (fault_ff || ret_bad) begin
               // A faulting instruction changes nothing but stops the machine.
               stopped_in    = 1'b1;
               res_halted_in = 1'b1;
               res_fault_in  = 1'b1;
            end else begin
               sp_in     = sp_new_ff;
               res_pc_in = pc_plus1;
               case (op_ff)
                  OP_EXIT: begin
                     stopped_in = 1'b1;
                     res_pc_in  = pc_ff;
                  end
                  OP_PUSH: begin
                     word_in[31:0] = a_ff;
                  end
                  OP_JUMP: begin
                     res_pc_in = pc_jmp_a;
                  end
                  OP_JIFNOT: begin
                     if (!bool_v) begin
                        res_pc_in = pc_jmp_a;
                     end
                  end
                  OP_JIFEQ: begin
                     if (fpu_rsp.flag) begin
                        res_pc_in = pc_jmp_b;
                     end
                  end
                  OP_CALL: begin
                     word_in   = {64'(base_ff), 64'({1'b0, pc_plus1} + (PC_WIDTH + 1)'(1))};
                     base_in   = sp_ff + PTR_W'(16);
                     res_pc_in = pc_jmp_a;
                  end
                  OP_RET: begin
                     base_in = bv[PTR_W-1:0];
                     if (rv == 64'd0) begin
                        stopped_in = 1'b1;
                        res_pc_in  = pc_ff;
                     end else begin
                        res_pc_in = rv[PC_WIDTH-1:0] - PC_WIDTH'(1);
                     end
                  end
                  OP_CONVERT: begin
                     if (a_ff == TYPE_FLOAT) begin
                        if (b_ff == TYPE_BOOL) begin
                           word_in[7:0] = {7'd0, (word_ff[30:0] != 31'd0)};
                        end else begin
                           word_in[31:0] = fpu_rsp.result;
                        end
                     end else if (b_ff == TYPE_FLOAT) begin
                        word_in[31:0] = bool_v ? FLOAT_ONE : 32'd0;
                     end else begin
                        word_in[31:0] = {31'd0, bool_v};
                     end
                  end
                  OP_ADD: begin
                     word_in[31:0] = fpu_rsp.result;
                  end
                  OP_PRINT: begin
                     res_pv_in   = 1'b1;
                     res_pval_in = word_ff[31:0];
                  end
                  OP_TEST: begin
                     res_tv_in = 1'b1;
                     res_tp_in = fpu_rsp.flag;
                  end
                  OP_LESS: begin
                     word_in[7:0] = {7'd0, fpu_rsp.flag};
                  end
                  default: begin
                     res_pc_in = pc_plus1;
                  end
               endcase
               res_halted_in = stopped_in;
               if (wr_len_ff != '0) begin
                  state_in = ST_WR;
               end
            end
            pc_in = res_pc_in;
         end
         ST_WR: begin
            if ((LEN_W'(cnt_ff) + LEN_W'(1)) == wr_len_ff) begin
               cnt_in   = '0;
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FIN: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {res_tp_ff, res_tv_ff, res_pval_ff, res_pv_ff,
                               res_fault_ff, res_halted_ff, res_pc_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         sp_ff        <= PTR_W'(16);
         base_ff      <= PTR_W'(16);
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         base_ff      <= base_in;
         pc_ff        <= pc_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      rd_addr_ff    <= rd_addr_in;
      rd_len_ff     <= rd_len_in;
      wr_addr_ff    <= wr_addr_in;
      wr_len_ff     <= wr_len_in;
      sp_new_ff     <= sp_new_in;
      fault_ff      <= fault_in;
      word_ff       <= word_in;
      res_pc_ff     <= res_pc_in;
      res_halted_ff <= res_halted_in;
      res_fault_ff  <= res_fault_in;
      res_pv_ff     <= res_pv_in;
      res_pval_ff   <= res_pval_in;
      res_tv_ff     <= res_tv_in;
      res_tp_ff     <= res_tp_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_FIELDS_W)'(0), rsp_data_ff};

endmodule

// ===== tb/byte_stack_bytecode_executor_tb.sv =====
// Self-checking testbench for byte_stack_bytecode_executor: streams bytecode
// requests, predicts each result with a bit-level machine model, checks it.
// Depends on bsbe_pkg and the executor RTL.
module byte_stack_bytecode_executor_tb;
   import bsbe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RANDOM_ITEMS = 450;
   localparam int  CYCLE_LIMIT  = 900000;
   localparam int  GEN          = 0;   // machine copy used to build the program
   localparam int  CHK          = 1;   // machine copy used to predict results
   localparam int  HOLD_CYCLES  = 300;

   typedef struct packed {
      logic        test_pass;
      logic        test_valid;
      logic [31:0] print_value;
      logic        print_valid;
      logic        fault;
      logic        halted;
      logic [15:0] next_pc;
   } step_result_t;

   typedef struct {
      opcode_type  op;
      logic [31:0] imm_a;
      logic [31:0] imm_b;
      bit          drain;   // wait for every result before sending this one
   } instr_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // Two copies of the machine state: one steers stimulus, one predicts.
   logic [7:0]  stack_mem [2][STACK_DEPTH_BYTES];
   int          stack_top [2];
   int          frame_base [2];
   logic [15:0] prog_ctr [2];
   bit          stopped [2];

   instr_t       program_queue[$];
   step_result_t expected_results[$];
   int           error_count = 0;
   int           requests_sent = 0;
   int           results_seen = 0;
   int           prints_seen = 0;
   int           tests_seen = 0;
   int           cycle_count = 0;
   int           random_count = 0;
   bit           req_taken = 1'b0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;
   bit           drain_marked = 1'b0;
   bit           drain_now = 1'b0;

   byte_stack_bytecode_executor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // ---------------- IEEE single helpers ----------------

   function automatic bit f_is_nan(logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 0);
   endfunction

   function automatic bit f_equal(logic [31:0] x, logic [31:0] y);
      if (f_is_nan(x) || f_is_nan(y)) return 1'b0;
      if (x[30:0] == 0 && y[30:0] == 0) return 1'b1;
      return x == y;
   endfunction

   function automatic bit f_less(logic [31:0] x, logic [31:0] y);
      if (f_is_nan(x) || f_is_nan(y)) return 1'b0;
      if (x[30:0] == 0 && y[30:0] == 0) return 1'b0;
      if (x[31] != y[31]) return x[31];
      if (!x[31]) return x[30:0] < y[30:0];
      return x[30:0] > y[30:0];
   endfunction

   // Truncating conversion that saturates and sends NaN to zero.
   function automatic logic [31:0] f_to_int(logic [31:0] x);
      int          e;
      logic [31:0] mag;
      e = x[30:23];
      if (f_is_nan(x)) return 32'd0;
      if (e >= 158) return x[31] ? INT_MIN_BITS : INT_MAX_BITS;
      if (e < 127) return 32'd0;
      mag = {8'd0, 1'b1, x[22:0]};
      if (e >= 150) mag = mag << (e - 150);
      else mag = mag >> (150 - e);
      return x[31] ? -mag : mag;
   endfunction

   // Round-to-nearest-even add, NaN handled as a scalar SSE unit does.
   function automatic logic [31:0] f_add(logic [31:0] x, logic [31:0] y);
      logic [31:0] big, tiny;
      logic [27:0] ma, mb, r;
      logic [24:0] m;
      int          ea, eb, d, e;
      bit          sticky, up, s;
      if (f_is_nan(x)) return x | 32'h0040_0000;
      if (f_is_nan(y)) return y | 32'h0040_0000;
      if (x[30:23] == 8'hFF && y[30:23] == 8'hFF && x[31] != y[31]) return FLOAT_QNAN;
      if (x[30:23] == 8'hFF) return x;
      if (y[30:23] == 8'hFF) return y;
      if (x[30:0] >= y[30:0]) begin
         big = x; tiny = y;
      end else begin
         big = y; tiny = x;
      end
      ea = (big[30:23] == 0) ? 1 : big[30:23];
      eb = (tiny[30:23] == 0) ? 1 : tiny[30:23];
      ma = {1'b0, big[30:23] != 0, big[22:0], 3'b000};
      mb = {1'b0, tiny[30:23] != 0, tiny[22:0], 3'b000};
      d = ea - eb;
      if (d >= 28) begin
         mb = (mb != 0) ? 28'd1 : 28'd0;
      end else if (d > 0) begin
         sticky = |(mb & ((28'd1 << d) - 28'd1));
         mb = (mb >> d) | {27'd0, sticky};
      end
      r = (big[31] == tiny[31]) ? ma + mb : ma - mb;
      if (r == 0) return {big[31] & tiny[31], 31'd0};
      s = big[31];
      e = ea;
      if (r[27]) begin
         r = (r >> 1) | {27'd0, r[0]};
         e++;
      end else begin
         while (!r[26] && e > 1) begin
            r = r << 1;
            e--;
         end
      end
      up = r[2] & (r[1] | r[0] | r[3]);
      m = {1'b0, r[26:3]} + {24'd0, up};
      if (m[24]) begin
         m = m >> 1;
         e++;
      end
      if (e >= 255) return {s, 8'hFF, 23'd0};
      return {s, m[23] ? 8'(e) : 8'd0, m[22:0]};
   endfunction

   // ---------------- machine model ----------------

   function automatic logic [63:0] mem_read(int k, int addr, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++)
         if (addr + i < STACK_DEPTH_BYTES) v |= 64'(stack_mem[k][addr + i]) << (8 * i);
      return v;
   endfunction

   function automatic void mem_write(int k, int addr, logic [63:0] v, int n);
      for (int i = 0; i < n; i++)
         if (addr + i < STACK_DEPTH_BYTES) stack_mem[k][addr + i] = v[8 * i +: 8];
   endfunction

   function automatic void push_bytes(int k, logic [63:0] v, int n);
      mem_write(k, stack_top[k], v, n);
      stack_top[k] += n;
   endfunction

   function automatic logic [63:0] pop_bytes(int k, int n);
      stack_top[k] -= n;
      return mem_read(k, stack_top[k], n);
   endfunction

   function automatic void machine_reset(int k);
      for (int i = 0; i < INIT_BYTES; i++) stack_mem[k][i] = 8'd0;
      stack_top[k] = 16;
      frame_base[k] = 16;
      prog_ctr[k] = '0;
      stopped[k] = 1'b0;
   endfunction

   // Executes one instruction on machine copy k and returns its result.
   function automatic step_result_t run_instruction(int k, opcode_type op,
                                                    logic [31:0] a, logic [31:0] b);
      step_result_t res;
      logic [15:0]  pc, nxt;
      longint       sa, addr;
      logic [63:0]  bv, rv;
      logic [31:0]  x, y;
      bit           bad, flag;
      res = '0;
      pc = prog_ctr[k];
      nxt = pc + 16'd1;
      bad = 1'b0;
      sa = longint'($signed(a));
      if (stopped[k]) begin
         res.next_pc = pc;
         res.halted = 1'b1;
         return res;
      end
      case (op)
         OP_EXIT: begin
            stopped[k] = 1'b1;
            nxt = pc;
         end
         OP_PUSH: begin
            if (stack_top[k] + 4 > STACK_DEPTH_BYTES) bad = 1'b1;
            else push_bytes(k, 64'(a), 4);
         end
         OP_POP: begin
            if (a > 32'(stack_top[k])) bad = 1'b1;
            else stack_top[k] -= int'(a);
         end
         OP_LOAD, OP_LOADPARAM: begin
            addr = (op == OP_LOAD) ? frame_base[k] + sa : frame_base[k] - 16 - sa;
            if (addr < 0 || addr + 4 > stack_top[k] ||
                stack_top[k] + 4 > STACK_DEPTH_BYTES) bad = 1'b1;
            else push_bytes(k, mem_read(k, int'(addr), 4), 4);
         end
         OP_STORE: begin
            addr = frame_base[k] + sa;
            if (stack_top[k] < 4 || addr < 0 || addr + 4 > stack_top[k] - 4) bad = 1'b1;
            else mem_write(k, int'(addr), pop_bytes(k, 4), 4);
         end
         OP_JUMP: nxt = pc + a[15:0];
         OP_JIFNOT: begin
            if (stack_top[k] < 1) bad = 1'b1;
            else if (pop_bytes(k, 1) == 0) nxt = pc + a[15:0];
         end
         OP_JIFEQ: begin
            if (stack_top[k] < 4) bad = 1'b1;
            else if (f_equal(a, 32'(pop_bytes(k, 4)))) nxt = pc + b[15:0];
         end
         OP_CALL: begin
            if (stack_top[k] + 16 > STACK_DEPTH_BYTES) bad = 1'b1;
            else begin
               // Return index is stored plus one so that zero means no caller.
               push_bytes(k, 64'(nxt) + 64'd1, 8);
               push_bytes(k, 64'(frame_base[k]), 8);
               frame_base[k] = stack_top[k];
               nxt = pc + a[15:0];
            end
         end
         OP_RET: begin
            if (stack_top[k] < 16) bad = 1'b1;
            else begin
               bv = mem_read(k, stack_top[k] - 8, 8);
               rv = mem_read(k, stack_top[k] - 16, 8);
               if (bv > STACK_DEPTH_BYTES) bad = 1'b1;
               else begin
                  stack_top[k] -= 16;
                  frame_base[k] = int'(bv);
                  if (rv == 0) begin
                     stopped[k] = 1'b1;
                     nxt = pc;
                  end else nxt = 16'(rv - 64'd1);
               end
            end
         end
         OP_CONVERT: begin
            if (a == b) begin
            end else if (a == TYPE_FLOAT) begin
               if (stack_top[k] < 4) bad = 1'b1;
               else begin
                  x = 32'(pop_bytes(k, 4));
                  if (b == TYPE_BOOL) push_bytes(k, 64'((x[30:0] != 0) ? 1 : 0), 1);
                  else if (b == TYPE_INT) push_bytes(k, 64'(f_to_int(x)), 4);
               end
            end else if (a == TYPE_BOOL) begin
               if (stack_top[k] < 1) bad = 1'b1;
               else if (b == TYPE_FLOAT && stack_top[k] + 3 > STACK_DEPTH_BYTES) bad = 1'b1;
               else begin
                  flag = pop_bytes(k, 1) != 0;
                  if (b == TYPE_FLOAT) push_bytes(k, 64'(flag ? FLOAT_ONE : 32'd0), 4);
                  else if (b == TYPE_INT) push_bytes(k, 64'(flag ? 1 : 0), 4);
               end
            end
         end
         OP_ADD, OP_TEST, OP_LESS: begin
            if (stack_top[k] < 8) bad = 1'b1;
            else begin
               x = 32'(pop_bytes(k, 4));
               y = 32'(pop_bytes(k, 4));
               if (op == OP_ADD) push_bytes(k, 64'(f_add(x, y)), 4);
               else if (op == OP_LESS) push_bytes(k, 64'(f_less(y, x) ? 1 : 0), 1);
               else begin
                  res.test_valid = 1'b1;
                  res.test_pass = f_equal(x, y);
               end
            end
         end
         OP_PRINT: begin
            if (stack_top[k] < 4) bad = 1'b1;
            else begin
               res.print_valid = 1'b1;
               res.print_value = 32'(pop_bytes(k, 4));
            end
         end
         default: ;
      endcase
      // A faulting instruction changes nothing and stops the machine.
      if (bad) begin
         stopped[k] = 1'b1;
         nxt = pc;
         res.fault = 1'b1;
      end
      prog_ctr[k] = nxt;
      res.next_pc = nxt;
      res.halted = stopped[k];
      return res;
   endfunction

   // ---------------- program generation ----------------

   function automatic void emit(opcode_type op, logic [31:0] a, logic [31:0] b,
                                bit drain = 1'b0);
      instr_t it;
      it.op = op;
      it.imm_a = a;
      it.imm_b = b;
      it.drain = drain;
      void'(run_instruction(GEN, op, a, b));
      program_queue.insert(program_queue.size(), it);
      random_count++;
   endfunction

   function automatic logic [31:0] rand_value();
      logic [31:0] specials [10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
         32'h7FC0_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, FLOAT_ONE,
         32'hFFFF_FFFF};
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return {1'($urandom), 8'($urandom_range(120, 135)), 23'($urandom)};
         2: return specials[$urandom_range(0, 9)];
         3: return 32'($urandom_range(0, 1));
         default: return 32'($urandom_range(0, 40));
      endcase
   endfunction

   function automatic logic [31:0] rand_type();
      case ($urandom_range(0, 4))
         0: return TYPE_FLOAT;
         1, 2: return TYPE_BOOL;
         3: return TYPE_INT;
         default: return $urandom;
      endcase
   endfunction

   // Emits a valid instruction that keeps the current frame intact, or pops the frame and returns.
   function automatic void emit_random(bit drain);
      int          fr, t, bs, addr;
      logic [31:0] from_t, to_t, v;
      opcode_type  op;
      t = stack_top[GEN];
      bs = frame_base[GEN];
      fr = t - bs;
      op = opcode_type'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) op = OP_PUSH;
      if (t > 2000 && $urandom_range(0, 1) == 0) op = OP_POP;
      case (op)
         OP_POP: begin
            emit(OP_POP, $urandom_range(0, fr), $urandom, drain);
            return;
         end
         OP_LOAD: if (fr >= 4) begin
            emit(OP_LOAD, $urandom_range(0, fr - 4), $urandom, drain);
            return;
         end
         OP_LOADPARAM: begin
            addr = $urandom_range(0, t - 4);
            emit(OP_LOADPARAM, 32'(bs - 16 - addr), $urandom, drain);
            return;
         end
         OP_STORE: if (fr >= 8) begin
            emit(OP_STORE, $urandom_range(0, fr - 8), $urandom, drain);
            return;
         end
         OP_JUMP: begin
            emit(OP_JUMP, ($urandom_range(0, 1) == 1) ? $urandom : 32'($urandom_range(0, 20)) - 10,
                 $urandom, drain);
            return;
         end
         OP_JIFNOT: if (fr >= 1) begin
            emit(OP_JIFNOT, $urandom, $urandom, drain);
            return;
         end
         OP_JIFEQ: if (fr >= 4) begin
            v = 32'(mem_read(GEN, t - 4, 4));
            emit(OP_JIFEQ, ($urandom_range(0, 1) == 1) ? v : rand_value(), $urandom, drain);
            return;
         end
         OP_CALL: if (t < 3000) begin
            emit(OP_CALL, $urandom, $urandom, drain);
            return;
         end
         OP_RET: if (bs > 16) begin
            if (fr > 0) emit(OP_POP, fr, $urandom, drain);
            emit(OP_RET, $urandom, $urandom);
            return;
         end
         OP_CONVERT: begin
            from_t = rand_type();
            to_t = rand_type();
            if ((from_t == TYPE_FLOAT && fr >= 4) || (from_t == TYPE_BOOL && fr >= 1) ||
                (from_t != TYPE_FLOAT && from_t != TYPE_BOOL) || from_t == to_t) begin
               emit(OP_CONVERT, from_t, to_t, drain);
               return;
            end
         end
         OP_ADD, OP_TEST, OP_LESS: if (fr >= 8) begin
            emit(op, $urandom, $urandom, drain);
            return;
         end
         OP_PRINT: if (fr >= 4) begin
            emit(OP_PRINT, $urandom, $urandom, drain);
            return;
         end
         default: ;
      endcase
      // Fallback keeps data flowing into the frame.
      if (t + 4 <= 4000) emit(OP_PUSH, rand_value(), $urandom, drain);
      else emit(OP_POP, fr, $urandom, drain);
   endfunction

   // Ends the program with exit, a return to the null caller, or a stack fault.
   function automatic void emit_ending();
      case ($urandom_range(0, 2))
         0: emit(OP_EXIT, $urandom, $urandom);
         1: begin
            while (frame_base[GEN] > 16) begin
               if (stack_top[GEN] > frame_base[GEN])
                  emit(OP_POP, stack_top[GEN] - frame_base[GEN], 0);
               emit(OP_RET, 0, 0);
            end
            if (stack_top[GEN] > 16) emit(OP_POP, stack_top[GEN] - 16, 0);
            emit(OP_RET, 0, 0);
         end
         default: emit(OP_POP, 32'hFFFF_FFFF, 0);
      endcase
      // A stopped machine only repeats its held state.
      for (int i = 0; i < 4; i++) emit(opcode_type'($urandom_range(0, 15)), $urandom, $urandom);
   endfunction

   // ---------------- stimulus ----------------

   initial begin
      machine_reset(GEN);
      machine_reset(CHK);

      // Directed: float add, print, compare, conversions, branches, call and return.
      emit(OP_PUSH, FLOAT_ONE, 32'h0);
      emit(OP_PUSH, 32'h4000_0000, 32'h0);
      emit(OP_ADD, 32'h0, 32'h0);
      emit(OP_PUSH, 32'h4040_0000, 32'h0);
      emit(OP_TEST, 32'h0, 32'h0);
      emit(OP_PUSH, 32'h7F80_0000, 32'h0);
      emit(OP_PUSH, 32'hFF80_0000, 32'h0);
      emit(OP_ADD, 32'h0, 32'h0);
      emit(OP_PRINT, 32'h0, 32'h0);
      emit(OP_PUSH, 32'h4F80_0000, 32'h0);
      emit(OP_CONVERT, TYPE_FLOAT, TYPE_INT);
      emit(OP_PUSH, 32'h8000_0000, 32'h0);
      emit(OP_CONVERT, TYPE_FLOAT, TYPE_BOOL);
      emit(OP_JIFNOT, 32'h8000_0000, 32'hFFFF_FFFF);
      emit(OP_PUSH, 32'h0000_0001, 32'h0);
      emit(OP_CONVERT, TYPE_FLOAT, TYPE_BOOL);
      emit(OP_CONVERT, TYPE_BOOL, TYPE_FLOAT);
      emit(OP_JIFEQ, FLOAT_ONE, 32'h7FFF_FFFF);
      emit(OP_PUSH, 32'hC000_0000, 32'h0);
      emit(OP_PUSH, 32'h4000_0000, 32'h0);
      emit(OP_LESS, 32'h0, 32'h0);
      emit(OP_CONVERT, TYPE_BOOL, TYPE_INT);
      emit(OP_JUMP, 32'h7FFF_FFFF, 32'h0);
      emit(OP_CALL, 32'd5, 32'h0);
      emit(OP_LOADPARAM, 32'h0, 32'h0);
      emit(OP_LOAD, 32'h0, 32'h0);
      emit(OP_STORE, 32'h0, 32'h0);
      emit(OP_POP, 32'd4, 32'h0);
      emit(OP_RET, 32'h0, 32'h0);
      emit(OP_CONVERT, TYPE_FLOAT, 32'd9);

      // Random programs; at most one request in the middle waits for a drained pipe.
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         drain_now = !drain_marked && (random_count >= RANDOM_ITEMS / 2);
         if (drain_now) drain_marked = 1'b1;
         emit_random(drain_now);
      end
      emit_ending();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (program_queue.size() == 0 && !req_tvalid && expected_results.size() == 0);
      repeat (100) @(posedge clock);
      $display("Ran %0d requests and checked %0d results (%0d prints, %0d tests),",
               requests_sent, results_seen, prints_seen, tests_seen);
      $display("covering every opcode, nested calls, float corners and a final halt.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Idle rates per phase: sender light then heavy, receiver the reverse, then none.
   function automatic int send_idle_pct();
      if (requests_sent < 160) return 6;
      if (requests_sent < 320) return 83;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (requests_sent < 160) return 83;
      if (requests_sent < 320) return 6;
      return 0;
   endfunction

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (program_queue.size() == 0 ||
             (program_queue[0].drain && expected_results.size() != 0) ||
             $urandom_range(0, 99) < send_idle_pct()) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_W'({program_queue[0].imm_b, program_queue[0].imm_a,
                                 4'(program_queue[0].op)});
            void'(program_queue.pop_front());
         end
      end
   end

   // Result receiver, with one long hold-off to back up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen == 150) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
   end

   function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, a);
         error_count++;
      end
   endfunction

   // Prediction on accepted requests and checking of accepted results.
   always @(posedge clock) begin
      step_result_t got, want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    run_instruction(CHK, opcode_type'(req_tdata[3:0]),
                                                    req_tdata[35:4], req_tdata[67:36]));
            requests_sent <= requests_sent + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(step_result_t)-1:0];
            results_seen <= results_seen + 1;
            if (got.print_valid) prints_seen <= prints_seen + 1;
            if (got.test_valid) tests_seen <= tests_seen + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("halted", want.halted, got.halted);
               check_field("fault", want.fault, got.fault);
               check_field("print_valid", want.print_valid, got.print_valid);
               check_field("print_value", want.print_value, got.print_value);
               check_field("test_valid", want.test_valid, got.test_valid);
               check_field("test_pass", want.test_pass, got.test_pass);
            end
         end
      end
   end

endmodule
